/* hw/rtl/ppba_pkg.sv */
// Shared constants for the page pool: default sizes, reset value of the
// page count register, mode codes and stream word widths.
// No dependencies.
package ppba_pkg;

	localparam int MAX_PAGES_DEF  = 64;
	localparam int PAGE_BYTES_DEF = 512;

	localparam logic [6:0] PAGE_COUNT_RST = 7'd64;

	localparam logic [2:0] MODE_ALLOC  = 3'd0;
	localparam logic [2:0] MODE_FREE   = 3'd1;
	localparam logic [2:0] MODE_WRITE  = 3'd2;
	localparam logic [2:0] MODE_READ   = 3'd3;
	localparam logic [2:0] MODE_APPEND = 3'd4;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 96;
	localparam int MAX_XFER   = 8;

endpackage

/* hw/rtl/ppba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

/* hw/rtl/page_pool_with_bounded_access_core.sv */
// Page pool: allocation bitmap, per-page fill marks and byte storage; one item in flight.
// An alloc scans upward from page zero for the lowest free page; write and append first
// zero any gap from the old fill mark; result and s_tready rise together. After reset and
// each page_count write a recount of the free pages among the first min(page_count,
// MAX_PAGES) runs with no item accepted. Depends on ppba_pkg and ppba_ram.
module page_pool_with_bounded_access_core #(
	parameter int MAX_PAGES  = ppba_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = ppba_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [6:0]                     cfg_data,   // page_count
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// page[5:0], offset[15:6], length[19:16], write_data[83:20], zero pad
	input  logic [ppba_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [2:0]                     s_tuser,    // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[0], alloc_index[6:1], read_data[70:7], free_pages[77:71],
	// page_in_use[78], page_fill[88:79], zero pad
	output logic [ppba_pkg::OUT_DATA_W-1:0] m_tdata
);

	import ppba_pkg::*;

	localparam int LIVE_W    = $clog2(MAX_PAGES + 1);
	localparam int CMP_W     = (LIVE_W > 7) ? LIVE_W : 7;
	localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int FILL_W    = $clog2(PAGE_BYTES + 1);
	localparam int POS_W     = (FILL_W > 10) ? FILL_W : 10;
	localparam int END_W     = POS_W + 1;
	localparam int MEM_DEPTH = MAX_PAGES * PAGE_BYTES;
	localparam int MA_W      = $clog2(MEM_DEPTH);

	localparam logic [3:0] S_RECOUNT = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_FRD     = 4'd3;
	localparam logic [3:0] S_DISP    = 4'd4;
	localparam logic [3:0] S_WR      = 4'd5;
	localparam logic [3:0] S_FWR     = 4'd6;
	localparam logic [3:0] S_RD      = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	// control state
	logic [3:0]           state_q;
	logic [6:0]           page_count_q;
	logic [LIVE_W-1:0]    i_q;
	logic [LIVE_W-1:0]    free_q;
	logic [MAX_PAGES-1:0] map_q;
	logic [MAX_PAGES-1:0] fill_vld_q;
	logic                 m_tvalid_q;
	logic                 rd_pend_s1;

	// item payload
	logic [2:0]            mode_q;
	logic [PG_W-1:0]       addr_q;
	logic                  avalid_q;
	logic [9:0]            off_q;
	logic [3:0]            len_q;
	logic [63:0]           wdata_q;
	logic [FILL_W-1:0]     fill_q;
	logic [POS_W-1:0]      at_q;
	logic [END_W-1:0]      end_q;
	logic [END_W-1:0]      ptr_q;
	logic                  status_q;
	logic [5:0]            aidx_q;
	logic [63:0]           rdata_q;
	logic [MA_W-1:0]       base_q;
	logic [2:0]            rd_k_s1;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              accept;
	logic [CMP_W-1:0]  page_ext;
	logic [LIVE_W-1:0] live;
	logic              scan_more;
	logic              map_i;
	logic              map_a;
	logic [FILL_W-1:0] fill_rdata;
	logic [FILL_W-1:0] fill_cur;
	logic [POS_W-1:0]  at_v;
	logic [END_W-1:0]  end_v;
	logic              len_ok;
	logic              in_bnd;
	logic              wr_ok;
	logic              rd_ok;
	logic              wr_more;
	logic [END_W-1:0]  rel;
	logic              in_gap;
	logic              fill_we;
	logic [MA_W-1:0]   byte_addr;
	logic              byte_we;
	logic [7:0]        byte_wdata;
	logic [7:0]        byte_rdata;
	logic              out_free;
	logic              res_in_use;
	logic [9:0]        res_fill;

	assign accept   = s_tvalid & s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign page_ext = CMP_W'(s_tdata[5:0]);

	assign live = (CMP_W'(page_count_q) > CMP_W'(MAX_PAGES)) ?
		LIVE_W'(MAX_PAGES) : LIVE_W'(page_count_q);

	assign scan_more = (i_q < live);
	assign map_i     = map_q[i_q[PG_W-1:0]];
	assign map_a     = map_q[addr_q];

	// an entry never written since reset or since its alloc reads as zero
	assign fill_cur = fill_vld_q[addr_q] ? fill_rdata : '0;
	assign at_v     = (mode_q == MODE_APPEND) ? POS_W'(fill_cur) : POS_W'(off_q);
	assign end_v    = END_W'(at_v) + END_W'(len_q);
	assign len_ok   = (len_q <= 4'(MAX_XFER));
	assign in_bnd   = (end_v <= END_W'(PAGE_BYTES));
	assign wr_ok    = avalid_q & len_ok & in_bnd;
	assign rd_ok    = wr_ok & (end_v <= END_W'(fill_cur));

	assign wr_more    = (ptr_q < end_q);
	assign rel        = ptr_q - END_W'(at_q);
	assign in_gap     = (ptr_q < END_W'(at_q));
	assign byte_addr  = base_q + MA_W'(ptr_q);
	assign byte_we    = (state_q == S_WR) & wr_more;
	assign byte_wdata = in_gap ? 8'd0 : wdata_q[8*rel[2:0] +: 8];
	assign fill_we    = (state_q == S_FWR) & (end_q > END_W'(fill_q));

	assign out_free   = ~m_tvalid_q | m_tready;
	assign res_in_use = avalid_q & map_a;
	assign res_fill   = avalid_q ? 10'(fill_q) : 10'd0;

	ppba_ram #(
		.WIDTH(FILL_W),
		.DEPTH(MAX_PAGES)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(addr_q),
		.wdata(FILL_W'(end_q)),
		.raddr(addr_q),
		.rdata(fill_rdata)
	);

	ppba_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_byte_ram (
		.clk  (clk),
		.we   (byte_we),
		.waddr(byte_addr),
		.wdata(byte_wdata),
		.raddr(byte_addr),
		.rdata(byte_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RECOUNT;
			page_count_q <= PAGE_COUNT_RST;
			i_q          <= '0;
			free_q       <= '0;
			map_q        <= '0;
			fill_vld_q   <= '0;
			m_tvalid_q   <= 1'b0;
			rd_pend_s1   <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == S_RD) & wr_more;
			// the done state loads the next item itself
			if (m_tready && (cfg_we || (state_q != S_DONE))) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				// a new page count restarts the free-page count
				page_count_q <= cfg_data;
				i_q          <= '0;
				free_q       <= '0;
				state_q      <= S_RECOUNT;
			end else begin
				unique case (state_q)
					S_RECOUNT: begin
						if (scan_more) begin
							if (!map_i) begin
								free_q <= free_q + 1'b1;
							end
							i_q <= i_q + 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (accept) begin
							i_q     <= '0;
							state_q <= (s_tuser == MODE_ALLOC) ? S_SCAN : S_FRD;
						end
					end
					S_SCAN: begin
						if (!scan_more) begin
							state_q <= S_DONE;
						end else if (!map_i) begin
							map_q[i_q[PG_W-1:0]]      <= 1'b1;
							fill_vld_q[i_q[PG_W-1:0]] <= 1'b0;
							free_q                    <= free_q - 1'b1;
							state_q                   <= S_DONE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
					S_FRD: begin
						state_q <= S_DISP;
					end
					S_DISP: begin
						unique case (mode_q) inside
							MODE_FREE: begin
								if (avalid_q & map_a) begin
									map_q[addr_q] <= 1'b0;
									free_q        <= free_q + 1'b1;
								end
								state_q <= S_DONE;
							end
							MODE_WRITE, MODE_APPEND: begin
								state_q <= wr_ok ? S_WR : S_DONE;
							end
							MODE_READ: begin
								state_q <= rd_ok ? S_RD : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
					S_WR: begin
						if (!wr_more) begin
							state_q <= S_FWR;
						end
					end
					S_FWR: begin
						if (fill_we) begin
							fill_vld_q[addr_q] <= 1'b1;
						end
						state_q <= S_DONE;
					end
					S_RD: begin
						// wait for the last byte still in the RAM read register
						if (!wr_more && !rd_pend_s1) begin
							state_q <= S_DONE;
						end
					end
					S_DONE: begin
						if (out_free) begin
							m_tvalid_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			rdata_q[8*rd_k_s1 +: 8] <= byte_rdata;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q   <= s_tuser;
					addr_q   <= page_ext[PG_W-1:0];
					avalid_q <= (s_tuser != MODE_ALLOC) & (page_ext < CMP_W'(live));
					off_q    <= s_tdata[15:6];
					len_q    <= s_tdata[19:16];
					wdata_q  <= s_tdata[83:20];
					fill_q   <= '0;
					status_q <= 1'b1;
					aidx_q   <= '0;
					rdata_q  <= '0;
				end
			end
			S_SCAN: begin
				if (scan_more && !map_i) begin
					status_q <= 1'b0;
					aidx_q   <= 6'(i_q);
					addr_q   <= i_q[PG_W-1:0];
					avalid_q <= 1'b1;
					fill_q   <= '0;
				end
			end
			S_FRD: begin
				base_q <= MA_W'(addr_q) * MA_W'(PAGE_BYTES);
			end
			S_DISP: begin
				fill_q <= fill_cur;
				at_q   <= at_v;
				end_q  <= end_v;
				unique case (mode_q) inside
					MODE_FREE: begin
						status_q <= 1'b0;
					end
					MODE_WRITE, MODE_APPEND: begin
						status_q <= ~wr_ok;
						// start at the old fill mark when a gap must be zeroed
						ptr_q <= (POS_W'(fill_cur) < at_v) ? END_W'(fill_cur) : END_W'(at_v);
					end
					MODE_READ: begin
						status_q <= ~rd_ok;
						ptr_q    <= END_W'(at_v);
					end
					default: begin
						status_q <= 1'b1;
					end
				endcase
			end
			S_WR: begin
				if (wr_more) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			S_FWR: begin
				if (fill_we) begin
					fill_q <= FILL_W'(end_q);
				end
			end
			S_RD: begin
				if (wr_more) begin
					rd_k_s1 <= rel[2:0];
					ptr_q   <= ptr_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {7'd0, res_fill, res_in_use, 7'(free_q), rdata_q, aidx_q,
						status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
